// ===== src/tc_pkg.sv =====
package tc_pkg;

   // Fixed-point layout: angle Q2.30, square Q3.60, accumulator Q4.60.
   localparam int ANGLE_W   = 32;
   localparam int SQ_W      = 63;
   localparam int ACC_W     = 64;
   localparam int PROD_W    = 128;
   localparam int FRAC_BITS = 60;
   localparam int OUT_FRAC  = 30;
   localparam int MAX_TERMS = 8;

   localparam logic [ACC_W-1:0] ONE_Q60 = 64'd1 << FRAC_BITS;

   // Coefficients 1/(2k)! in Q4.60, rounded to nearest with ties up.
   localparam logic [ACC_W-1:0] COEF_TABLE [MAX_TERMS] = '{
      (ONE_Q60 + 64'd0) / 64'd1,
      (ONE_Q60 + 64'd1) / 64'd2,
      (ONE_Q60 + 64'd12) / 64'd24,
      (ONE_Q60 + 64'd360) / 64'd720,
      (ONE_Q60 + 64'd20160) / 64'd40320,
      (ONE_Q60 + 64'd1814400) / 64'd3628800,
      (ONE_Q60 + 64'd239500800) / 64'd479001600,
      (ONE_Q60 + 64'd43589145600) / 64'd87178291200
   };

   localparam logic [ACC_W:0]         ROUND_HALF = 65'd1 << (OUT_FRAC - 1);
   localparam logic [ANGLE_W+2:0]     NEG_LIMIT  = 35'h0_8000_0000;
   localparam logic [ANGLE_W+2:0]     POS_LIMIT  = 35'h0_7FFF_FFFF;
   localparam logic [ANGLE_W-1:0]     NEG_SAT    = 32'h8000_0000;
   localparam logic [ANGLE_W-1:0]     POS_SAT    = 32'h7FFF_FFFF;

   // Word handed from one Horner cell to the next.
   typedef struct packed {
      logic                    valid;
      logic [SQ_W-1:0]         sq;
      logic signed [ACC_W-1:0] acc;
   } link_type;

   // One stage of the multiplier inside a cell.
   typedef struct packed {
      logic              valid;
      logic              neg;
      logic [ACC_W-1:0]  mag;
      logic [SQ_W-1:0]   sq;
      logic [PROD_W-1:0] prod;
   } stage_type;

endpackage

// ===== src/tc_cell.sv =====
// One Horner step: acc_out = coef - trunc(acc_in * sq), pipelined over six registers.
module tc_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic [tc_pkg::ACC_W-1:0]         coef,
   input  tc_pkg::link_type                 link_in,
   output tc_pkg::link_type                 link_out
);

   localparam int NSTG = 5;

   tc_pkg::stage_type stg_ff [NSTG];
   tc_pkg::stage_type stg_in [NSTG];
   tc_pkg::link_type  out_ff;
   tc_pkg::link_type  out_in;

   logic [tc_pkg::ACC_W-1:0] mag_in;
   logic [tc_pkg::ACC_W-1:0] sqx1, sqx2, sqx3, sqx4;
   logic [63:0]              pp1, pp2, pp3, pp4;
   logic [tc_pkg::ACC_W-1:0] prod_q60;

   assign mag_in = link_in.acc[tc_pkg::ACC_W-1] ? (~link_in.acc + 64'd1) : link_in.acc;

   assign sqx1 = {1'b0, stg_ff[0].sq};
   assign sqx2 = {1'b0, stg_ff[1].sq};
   assign sqx3 = {1'b0, stg_ff[2].sq};
   assign sqx4 = {1'b0, stg_ff[3].sq};

   // One 32x32 partial product per stage.
   assign pp1 = stg_ff[0].mag[31:0]  * sqx1[31:0];
   assign pp2 = stg_ff[1].mag[31:0]  * sqx2[63:32];
   assign pp3 = stg_ff[2].mag[63:32] * sqx3[31:0];
   assign pp4 = stg_ff[3].mag[63:32] * sqx4[63:32];

   always_comb begin
      stg_in[0].valid = link_in.valid;
      stg_in[0].neg   = link_in.acc[tc_pkg::ACC_W-1];
      stg_in[0].mag   = mag_in;
      stg_in[0].sq    = link_in.sq;
      stg_in[0].prod  = '0;
      for (int i = 1; i < NSTG; i++) begin
         stg_in[i] = stg_ff[i-1];
      end
      stg_in[1].prod = {64'd0, pp1};
      stg_in[2].prod = stg_ff[1].prod + {32'd0, pp2, 32'd0};
      stg_in[3].prod = stg_ff[2].prod + {32'd0, pp3, 32'd0};
      stg_in[4].prod = stg_ff[3].prod + {pp4, 64'd0};
   end

   // The product magnitude is truncated to Q.60 before the sign is applied.
   assign prod_q60 = stg_ff[NSTG-1].prod[tc_pkg::FRAC_BITS+tc_pkg::ACC_W-1:tc_pkg::FRAC_BITS];

   always_comb begin
      out_in.valid = stg_ff[NSTG-1].valid;
      out_in.sq    = stg_ff[NSTG-1].sq;
      out_in.acc   = stg_ff[NSTG-1].neg ? $signed(coef + prod_q60) : $signed(coef - prod_q60);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTG; i++) begin
            stg_ff[i].valid <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         stg_ff <= stg_in;
         out_ff <= out_in;
      end
   end

   assign link_out = out_ff;

endmodule

// ===== src/taylor_cosine.sv =====
// taylor_cosine: eight-term Maclaurin series for cosine in signed Q2.30.
//
// Input channel req_: present an angle on req_angle with req_valid high; the
// word is taken at a rising edge where req_stall is low. Output channel rsp_:
// rsp_cosine is valid while rsp_valid is high and is taken at an edge where
// rsp_stall is low. Each angle gives exactly one cosine word, in order.
//
// Throughput is one word per cycle while the skid register is empty. From
// acceptance to rsp_valid a word passes the square register; in each Horner
// cell a magnitude register, four 32x32 partial-product registers and a
// subtract-from-coefficient register; the first and second rounding
// registers, which round and saturate; and the output register.
//
// The whole pipeline advances together. An output register and a skid
// register sit at the end, so a new word is still accepted while a finished
// result waits on a stalled receiver; req_stall is raised only once the skid
// register holds a word, and is itself a flop output.
//
// Reset (synchronous, active high) empties every stage; nothing else is kept.
module taylor_cosine #(
   parameter int SERIES_LIMIT = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [tc_pkg::ANGLE_W-1:0]  req_angle,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [tc_pkg::ANGLE_W-1:0]  rsp_cosine
);

   // Number of series terms, clamped to at least one and to what the coefficient table holds.
   localparam int TERMS_RAW = (SERIES_LIMIT + 1) / 2;
   localparam int TERMS     = (TERMS_RAW > tc_pkg::MAX_TERMS) ? tc_pkg::MAX_TERMS :
                              (TERMS_RAW < 1) ? 1 : TERMS_RAW;
   localparam int NUM_CELLS = TERMS - 1;

   logic adv;

   // Square stage: s = x*x is exact and never above 4.0 in Q3.60.
   logic signed [2*tc_pkg::ANGLE_W-1:0] sq_full;
   tc_pkg::link_type                    link [NUM_CELLS+1];
   tc_pkg::link_type                    sq_ff;
   tc_pkg::link_type                    sq_in;

   assign sq_full = req_angle * req_angle;

   always_comb begin
      sq_in.valid = req_valid;
      sq_in.sq    = sq_full[tc_pkg::SQ_W-1:0];
      sq_in.acc   = $signed(tc_pkg::COEF_TABLE[TERMS-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff.valid <= 1'b0;
      end else if (adv) begin
         sq_ff <= sq_in;
      end
   end

   assign link[0] = sq_ff;

   // Chain of Horner cells, highest-order coefficient first.
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      tc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .coef     (tc_pkg::COEF_TABLE[TERMS-2-i]),
         .link_in  (link[i]),
         .link_out (link[i+1])
      );
   end

   // Rounding, first half: sign and magnitude of the Q4.60 sum.
   logic                     rnd1_valid_ff;
   logic                     rnd1_neg_ff;
   logic [tc_pkg::ACC_W-1:0] rnd1_mag_ff;
   logic                     acc_neg;
   logic [tc_pkg::ACC_W-1:0] acc_mag;

   assign acc_neg = link[NUM_CELLS].acc[tc_pkg::ACC_W-1];
   assign acc_mag = acc_neg ? (~link[NUM_CELLS].acc + 64'd1) : link[NUM_CELLS].acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd1_valid_ff <= 1'b0;
      end else if (adv) begin
         rnd1_valid_ff <= link[NUM_CELLS].valid;
         rnd1_neg_ff   <= acc_neg;
         rnd1_mag_ff   <= acc_mag;
      end
   end

   // Rounding, second half: to nearest on the magnitude with ties away from
   // zero, then clamp to the Q2.30 range and restore the sign.
   logic [tc_pkg::ACC_W:0]     rnd_sum;
   logic [tc_pkg::ANGLE_W+2:0] rnd_q;
   logic [tc_pkg::ANGLE_W-1:0] rnd_lim;
   logic [tc_pkg::ANGLE_W-1:0] rnd_word;
   logic                       rnd2_valid_ff;
   logic [tc_pkg::ANGLE_W-1:0] rnd2_word_ff;

   assign rnd_sum = {1'b0, rnd1_mag_ff} + tc_pkg::ROUND_HALF;
   assign rnd_q   = rnd_sum[tc_pkg::ACC_W:tc_pkg::OUT_FRAC];

   always_comb begin
      if (rnd1_neg_ff) begin
         rnd_lim  = (rnd_q > tc_pkg::NEG_LIMIT) ? tc_pkg::NEG_SAT : rnd_q[tc_pkg::ANGLE_W-1:0];
         rnd_word = ~rnd_lim + 32'd1;
      end else begin
         rnd_lim  = (rnd_q > tc_pkg::POS_LIMIT) ? tc_pkg::POS_SAT : rnd_q[tc_pkg::ANGLE_W-1:0];
         rnd_word = rnd_lim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd2_valid_ff <= 1'b0;
      end else if (adv) begin
         rnd2_valid_ff <= rnd1_valid_ff;
         rnd2_word_ff  <= rnd_word;
      end
   end

   // Output register with a skid register behind it. The pipeline only
   // moves while the skid register is empty, so a word arriving while the
   // output is held has somewhere to go.
   logic                       out_valid_ff, out_valid_in;
   logic [tc_pkg::ANGLE_W-1:0] out_word_ff, out_word_in;
   logic                       skid_valid_ff, skid_valid_in;
   logic [tc_pkg::ANGLE_W-1:0] skid_word_ff, skid_word_in;
   logic                       arrive;
   logic                       drain;

   assign adv    = !skid_valid_ff;
   assign arrive = rnd2_valid_ff && adv;
   assign drain  = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (drain) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = arrive;
            out_word_in  = rnd2_word_ff;
         end
      end else if (arrive) begin
         skid_valid_in = 1'b1;
         skid_word_in  = rnd2_word_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign req_stall  = skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_cosine = $signed(out_word_ff);

`ifndef ASSERT_OFF
   // The skid register is only ever occupied behind a full output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a word while the output is empty");

   // A word only parks in the skid register when the output was held.
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      !skid_valid_ff ##1 skid_valid_ff |-> $past(out_valid_ff && rsp_stall))
      else $error("skid register filled without a stalled output");

   // While the skid register is full the pipeline is frozen and no word is taken.
   a_frozen: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(rnd2_word_ff) && $stable(rnd2_valid_ff))
      else $error("pipeline moved while the skid register was full");
`endif

endmodule
